// ===== src/epoch_topic_blake2b_derive_top_macros.svh =====
// Assertion macros shared by the checker of the topic derivation block.
`ifndef EPOCH_TOPIC_BLAKE2B_DERIVE_TOP_MACROS_SVH
`define EPOCH_TOPIC_BLAKE2B_DERIVE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ETB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define ETB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset
`define ETB_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/etb_pkg.sv =====
// Types, constants and helper functions for the topic derivation block.
package etb_pkg;

  localparam logic [31:0] PERIOD_RESET = 32'd3600;
  localparam logic [63:0] MSG_LEN = 64'd40;
  localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0000;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [3:0] SIGMA [10][16] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
      4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
    '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
      4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
    '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
      4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
    '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
      4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
    '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
      4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
    '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
      4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
    '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
      4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
    '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
      4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
    '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
      4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
  };

  // One hash job handed from the front to the back
  typedef struct packed {
    logic [4:0][63:0] msg;
    logic [63:0]      epoch;
    logic [32:0]      secs;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic logic [63:0] swap64(input logic [63:0] x);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = x[56 - 8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'd0, n};
    else c = 8'h57 + {4'd0, n};
    return c;
  endfunction

endpackage

// ===== src/etb_front.sv =====
// Front end: accepts items, divides the time by the period, builds the hash message.
module etb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [63:0]        key_word_0,
  input  logic [63:0]        key_word_1,
  input  logic [63:0]        key_word_2,
  input  logic [63:0]        key_word_3,
  input  logic [63:0]        time_value,
  input  logic [31:0]        period,
  input  etb_pkg::fifo_stat_t q_stat,
  output logic               push,
  output etb_pkg::job_t      push_job
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]  st;
  logic        is_epoch;
  logic        neg;
  logic [63:0] key0, key1, key2, key3, tval;
  logic [31:0] p;
  logic [63:0] quo, quo_next;
  logic [31:0] rem, rem_next;
  logic [3:0]  cnt;
  logic        accept;
  logic [63:0] epoch;
  logic [32:0] secs;

  assign in_stall = (st == ST_DIV) || ((st == ST_PUSH) && q_stat.full);
  assign accept   = in_valid && !in_stall;
  assign push     = (st == ST_PUSH) && !q_stat.full;

  // Four restoring division steps per cycle
  always_comb begin
    logic [32:0] t33;
    logic [31:0] r;
    logic [63:0] q;
    r = rem;
    q = quo;
    for (int j = 0; j < 4; j++) begin
      t33 = {r, q[63]};
      q = {q[62:0], 1'b0};
      if (t33 >= {1'b0, p}) begin
        t33 = t33 - {1'b0, p};
        q[0] = 1'b1;
      end
      r = t33[31:0];
    end
    quo_next = q;
    rem_next = r;
  end

  // Form the epoch, the seconds left and the message words
  always_comb begin
    if (is_epoch) begin
      epoch = tval;
      secs  = 33'd0;
    end else if (neg) begin
      epoch = 64'd0 - quo;
      secs  = {1'b0, p} + {1'b0, rem};
    end else begin
      epoch = quo;
      secs  = {1'b0, p} - {1'b0, rem};
    end
    push_job.msg[0] = etb_pkg::swap64(key0);
    push_job.msg[1] = etb_pkg::swap64(key1);
    push_job.msg[2] = etb_pkg::swap64(key2);
    push_job.msg[3] = etb_pkg::swap64(key3);
    push_job.msg[4] = etb_pkg::swap64(epoch);
    push_job.epoch  = epoch;
    push_job.secs   = secs;
  end

  // Control: load on accept, iterate, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_IDLE;
      cnt <= 4'd0;
    end else begin
      if (accept) begin
        st  <= cmd ? ST_PUSH : ST_DIV;
        cnt <= 4'd0;
      end else if (st == ST_DIV) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) st <= ST_PUSH;
      end else if (push) begin
        st <= ST_IDLE;
      end
    end
  end

  // Payload: operands and divider registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_epoch <= cmd;
      key0     <= key_word_0;
      key1     <= key_word_1;
      key2     <= key_word_2;
      key3     <= key_word_3;
      tval     <= time_value;
      neg      <= time_value[63];
      p        <= (period == 32'd0) ? 32'd1 : period;
      quo      <= time_value[63] ? (64'd0 - time_value) : time_value;
      rem      <= 32'd0;
    end else if (st == ST_DIV) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

// ===== src/etb_fifo.sv =====
// Two-entry queue that decouples the front end from the hash engine.
module etb_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  etb_pkg::job_t       push_job,
  input  logic                pop,
  output etb_pkg::job_t       pop_job,
  output etb_pkg::fifo_stat_t stat
);

  etb_pkg::job_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);
  assign pop_job    = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

endmodule

// ===== src/etb_back.sv =====
// Hash engine: single-block BLAKE2b with four shared half-mix lanes, plus result register.
module etb_back #(
  parameter int DIGEST_BYTES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  etb_pkg::fifo_stat_t q_stat,
  input  etb_pkg::job_t       job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         topic_text_0,
  output logic [63:0]         topic_text_1,
  output logic [63:0]         topic_text_2,
  output logic [63:0]         topic_text_3,
  output logic [63:0]         epoch_out,
  output logic [32:0]         secs_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [63:0] H0 = etb_pkg::IV[0] ^ etb_pkg::PARAM_WORD ^ 64'(DIGEST_BYTES);

  logic [1:0]       st;
  logic [3:0]       rnd;
  logic [1:0]       phase;
  logic [3:0]       rnd_sel;
  logic [63:0]      v [16];
  logic [63:0]      v_next [16];
  logic [4:0][63:0] msg;
  logic [63:0]      epoch_r;
  logic [32:0]      secs_r;
  logic [255:0]     text;
  logic             out_load;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  assign pop      = (st == ST_IDLE) && !q_stat.empty;
  assign out_load = (st == ST_DONE) && (!out_valid || !out_stall);
  assign rnd_sel  = (rnd >= 4'd10) ? (rnd - 4'd10) : rnd;

  // Four half-mix lanes; phase bit 1 picks diagonals, bit 0 the second half
  always_comb begin
    logic [3:0]  ia, ib, ic, id, k, sg;
    logic [63:0] a, b, c, d, x, an, bn, cn, dn;
    for (int n = 0; n < 16; n++) v_next[n] = v[n];
    for (int i = 0; i < 4; i++) begin
      ia = 4'(i);
      ib = phase[1] ? 4'(4 + ((i + 1) & 3)) : 4'(4 + i);
      ic = phase[1] ? 4'(8 + ((i + 2) & 3)) : 4'(8 + i);
      id = phase[1] ? 4'(12 + ((i + 3) & 3)) : 4'(12 + i);
      k  = 4'((phase[1] ? 8 : 0) + 2 * i) | {3'd0, phase[0]};
      sg = etb_pkg::SIGMA[rnd_sel][k];
      x  = (sg < 4'd5) ? msg[sg[2:0]] : 64'd0;
      a  = v[ia];
      b  = v[ib];
      c  = v[ic];
      d  = v[id];
      an = a + b + x;
      dn = phase[0] ? rotr(d ^ an, 16) : rotr(d ^ an, 32);
      cn = c + dn;
      bn = phase[0] ? rotr(b ^ cn, 63) : rotr(b ^ cn, 24);
      v_next[ia] = an;
      v_next[ib] = bn;
      v_next[ic] = cn;
      v_next[id] = dn;
    end
  end

  // Fold the state into the digest and spell it in hex
  always_comb begin
    logic [127:0] dig;
    logic [7:0]   byt;
    dig  = {etb_pkg::IV[1] ^ v[1] ^ v[9], H0 ^ v[0] ^ v[8]};
    text = 256'd0;
    for (int i = 0; i < 16; i++) begin
      byt = dig[8*i +: 8];
      if (i < DIGEST_BYTES) begin
        text[255 - 16*i -: 8] = etb_pkg::hex_char(byt[7:4]);
        text[247 - 16*i -: 8] = etb_pkg::hex_char(byt[3:0]);
      end
    end
  end

  // Sequencer: load a job, run twelve rounds of four half-steps, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      rnd   <= 4'd0;
      phase <= 2'd0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (pop) begin
            st    <= ST_RUN;
            rnd   <= 4'd0;
            phase <= 2'd0;
          end
        end
        ST_RUN: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) begin
            rnd <= rnd + 4'd1;
            if (rnd == 4'd11) st <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) st <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Working state and job payload
  always_ff @(posedge clk) begin
    if (pop) begin
      msg     <= job.msg;
      epoch_r <= job.epoch;
      secs_r  <= job.secs;
      v[0]    <= H0;
      for (int n = 1; n < 8; n++) v[n] <= etb_pkg::IV[n];
      for (int n = 0; n < 8; n++) v[8 + n] <= etb_pkg::IV[n];
      v[12]   <= etb_pkg::IV[4] ^ etb_pkg::MSG_LEN;
      v[14]   <= ~etb_pkg::IV[6];
    end else if (st == ST_RUN) begin
      for (int n = 0; n < 16; n++) v[n] <= v_next[n];
    end
  end

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      topic_text_0 <= text[255:192];
      topic_text_1 <= text[191:128];
      topic_text_2 <= text[127:64];
      topic_text_3 <= text[63:0];
      epoch_out    <= epoch_r;
      secs_out     <= secs_r;
    end
  end

endmodule

// ===== src/epoch_topic_blake2b_derive_top.sv =====
// Front end: an epoch item skips the divider; a time item first runs the 16-step divider.
// The hash engine then runs BLAKE2b (12 rounds x 4 half-mix steps on four lanes) and hands over.
// Throughput is set by the shared mixing lanes: the hash engine takes a new item only when idle;
// a two-entry queue lets the divider work on the next item meanwhile.
// Reset: synchronous, active high; clears all control state, period returns to 3600.
module epoch_topic_blake2b_derive_top #(
  parameter int DIGEST_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        epoch_period_seconds,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [63:0]        key_word_0,
  input  logic [63:0]        key_word_1,
  input  logic [63:0]        key_word_2,
  input  logic [63:0]        key_word_3,
  input  logic signed [63:0] time_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        topic_text_0,
  output logic [63:0]        topic_text_1,
  output logic [63:0]        topic_text_2,
  output logic [63:0]        topic_text_3,
  output logic signed [63:0] epoch_number,
  output logic [32:0]        seconds_to_next_epoch
);

  logic                period;
  logic [31:0]         period_r;
  logic                push, pop;
  etb_pkg::job_t       push_job, pop_job;
  etb_pkg::fifo_stat_t q_stat;
  logic [63:0]         epoch_u;

  assign cfg_ready    = 1'b1;
  assign period       = cfg_valid && cfg_ready;
  assign epoch_number = $signed(epoch_u);

  // Period register
  always_ff @(posedge clk) begin
    if (rst) begin
      period_r <= etb_pkg::PERIOD_RESET;
    end else if (period) begin
      period_r <= epoch_period_seconds;
    end
  end

  etb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .key_word_0 (key_word_0),
    .key_word_1 (key_word_1),
    .key_word_2 (key_word_2),
    .key_word_3 (key_word_3),
    .time_value ($unsigned(time_value)),
    .period     (period_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  etb_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  etb_back #(
    .DIGEST_BYTES (DIGEST_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .job          (pop_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .topic_text_0 (topic_text_0),
    .topic_text_1 (topic_text_1),
    .topic_text_2 (topic_text_2),
    .topic_text_3 (topic_text_3),
    .epoch_out    (epoch_u),
    .secs_out     (seconds_to_next_epoch)
  );

endmodule

// ===== src/etb_checker.sv =====
// Port-level checker for the topic derivation block, bound to the top level.
`include "epoch_topic_blake2b_derive_top_macros.svh"

module etb_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] topic_text_0
);

  // A stalled result beat stays offered
  `ETB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // Reset leaves no result pending
  `ETB_ASSERT_RST(a_rst_clear, rst, !out_valid, "result valid right after reset")

  // The period register takes every write
  `ETB_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

  // The first topic character is always a lower-case hex digit
  `ETB_ASSERT_NOW(a_hex_char, out_valid, ((topic_text_0[63:56] >= 8'h30) && (topic_text_0[63:56] <= 8'h39)) || ((topic_text_0[63:56] >= 8'h61) && (topic_text_0[63:56] <= 8'h66)), "topic character not hex")

endmodule

bind epoch_topic_blake2b_derive_top etb_checker u_checker (.*);
